// ===== rtl/mfr_pkg.sv =====
package mfr_pkg;

  typedef enum logic [1:0] {
    OP_RX       = 2'd0,
    OP_READ     = 2'd1,
    OP_CLR_MODE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_ZIGBEE  = 3'd1,
    EV_CUSTOM  = 3'd2,
    EV_DISCARD = 3'd3,
    EV_MODE    = 3'd4
  } event_t;

  localparam logic [7:0] HEAD_ZIGBEE = 8'h55;
  localparam logic [7:0] HEAD_CRLF   = 8'hC1;
  localparam logic [7:0] CUSTOM_B1   = 8'hC2;
  localparam logic [7:0] CUSTOM_B2   = 8'hC3;
  localparam logic [7:0] CUSTOM_B3   = 8'hC4;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] HEAD_MODE   = 8'h42; // 'B'
  localparam logic [7:0] CHAR_U      = 8'h55;
  localparam logic [7:0] CHAR_S      = 8'h53;
  localparam logic [7:0] CHAR_Y      = 8'h59;

  // result of one item as computed at acceptance; read data from the banks joins it at the output
  typedef struct packed {
    event_t      event_res;
    logic [8:0]  frame_length;
    logic        mode_flag;
    logic        from_mem;
    logic        bank_odd;
    logic [7:0]  reg_data;
  } res_t;

endpackage

// ===== rtl/mfr_in_if.sv =====
interface mfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;
  logic [7:0] read_index;

  modport source(output valid, output operation, output rx_byte, output read_index,
                 input ready);
  modport sink(input valid, input operation, input rx_byte, input read_index,
               output ready);
endinterface

// ===== rtl/mfr_out_if.sv =====
interface mfr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [8:0] frame_length;
  logic [7:0] read_data;
  logic       mode_flag;

  modport source(output valid, output event_res, output frame_length, output read_data,
                 output mode_flag, input ready);
  modport sink(input valid, input event_res, input frame_length, input read_data,
               input mode_flag, output ready);
endinterface

// ===== rtl/mfr_bank_ram.sv =====
module mfr_bank_ram #(
  parameter int ROWS = 128
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [$clog2(ROWS)-1:0] wrow,
  input  logic [7:0]              wdata,
  input  logic                    re,
  input  logic [$clog2(ROWS)-1:0] rrow,
  output logic [7:0]              rdata
);

  logic [7:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wrow] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[rrow];
    end
  end

endmodule

// ===== rtl/mfr_frame_ctrl.sv =====
module mfr_frame_ctrl #(
  parameter int BUF_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [1:0]           operation,
  input  logic [7:0]           rx_byte,
  input  logic [7:0]           read_index,
  output logic                 busy,
  output logic [1:0]           mem_we,
  output logic [$clog2((BUF_DEPTH+1)/2)-1:0] mem_wrow [2],
  output logic [7:0]           mem_wdata [2],
  output logic                 mem_re,
  output logic [$clog2((BUF_DEPTH+1)/2)-1:0] mem_rrow,
  output mfr_pkg::res_t        res
);
  import mfr_pkg::*;

  localparam int ROWS  = (BUF_DEPTH + 1) / 2;
  localparam int ROW_W = $clog2(ROWS);
  localparam int FC_MAX = (BUF_DEPTH > 258) ? BUF_DEPTH : 258;
  localparam int FC_W  = $clog2(FC_MAX + 2);

  // entries 0..3 live in flops; the banks hold everything from entry 4 up
  logic [7:0]      ent_r [4];
  logic [7:0]      ent_nxt [4];
  logic [FC_W-1:0] fill_r, fill_nxt;
  logic            cr_r, cr_nxt;
  logic            mode_r, mode_nxt;
  logic            clr_active_r;
  logic [ROW_W-1:0] clr_row_r;

  assign busy = clr_active_r;

  always_comb begin
    logic [FC_W-1:0] fc;
    logic            cr;
    logic            md;
    logic [7:0]      e [4];
    event_t          ev;
    logic            fin;
    logic [FC_W-1:0] pa [2];
    logic [7:0]      pd [2];
    logic            pv [2];
    logic [FC_W-1:0] want;
    logic [FC_W-1:0] ridx;
    logic [FC_W-1:0] sh;
    logic [7:0]      b;

    fc   = fill_r;
    cr   = cr_r;
    md   = mode_r;
    e    = ent_r;
    ev   = EV_NONE;
    fin  = 1'b0;
    pa   = '{default: '0};
    pd   = '{default: '0};
    pv   = '{default: 1'b0};
    want = '0;
    b    = rx_byte;
    ridx = FC_W'(read_index);
    sh   = '0;

    res.event_res    = EV_NONE;
    res.frame_length = '0;
    res.mode_flag    = 1'b0;
    res.from_mem     = 1'b0;
    res.bank_odd     = read_index[0];
    res.reg_data     = '0;
    mem_re           = 1'b0;
    sh               = ridx >> 1;
    mem_rrow         = sh[ROW_W-1:0];

    case (op_t'(operation))
      OP_RX: begin
        if (e[0] == HEAD_CRLF) begin
          if (cr) begin
            if (b == CHAR_LF) begin
              fin = 1'b1;
            end else begin
              // lone CR is kept as data ahead of this byte
              cr = 1'b0;
              if (fc < FC_W'(4)) e[fc[1:0]] = CHAR_CR;
              else begin pv[0] = 1'b1; pa[0] = fc; pd[0] = CHAR_CR; end
              fc = fc + 1'b1;
              if (fc < FC_W'(4)) e[fc[1:0]] = b;
              else begin pv[1] = 1'b1; pa[1] = fc; pd[1] = b; end
              fc = fc + 1'b1;
              if (fc > FC_W'(BUF_DEPTH - 1)) begin
                fc = '0;
                cr = 1'b0;
              end
            end
          end else if (b == CHAR_CR) begin
            cr = 1'b1;
          end else begin
            if (fc < FC_W'(4)) e[fc[1:0]] = b;
            else begin pv[0] = 1'b1; pa[0] = fc; pd[0] = b; end
            fc = fc + 1'b1;
            if (fc > FC_W'(BUF_DEPTH - 1)) begin
              fc = '0;
              cr = 1'b0;
            end
          end
        end else if (e[0] == HEAD_ZIGBEE) begin
          if (fc < FC_W'(4)) e[fc[1:0]] = b;
          else begin pv[0] = 1'b1; pa[0] = fc; pd[0] = b; end
          fc   = fc + 1'b1;
          want = FC_W'(e[1]) + FC_W'(2);
          if (want == fc) begin
            fin = 1'b1;
          end else if (want < fc) begin
            // overrun: drop the frame silently
            fc   = '0;
            cr   = 1'b0;
            e[0] = '0;
            e[1] = '0;
          end
        end else if (e[0] == HEAD_MODE) begin
          if (b != CHAR_U && b != CHAR_S && b != CHAR_Y) begin
            cr   = 1'b0;
            e[1] = '0;
            e[0] = b;
            fc   = FC_W'(1);
          end else begin
            if (fc < FC_W'(4)) e[fc[1:0]] = b;
            else begin pv[0] = 1'b1; pa[0] = fc; pd[0] = b; end
            fc = fc + 1'b1;
          end
          if (fc == FC_W'(4)) begin
            if (!md) begin
              md = 1'b1;
              ev = EV_MODE;
            end
          end else if (fc > FC_W'(4)) begin
            cr   = 1'b0;
            e[1] = '0;
            e[0] = b;
            fc   = FC_W'(1);
          end
        end else if (e[0] == 8'h00) begin
          e[1] = '0;
          e[0] = b;
          if (fc >= FC_W'(BUF_DEPTH - 1)) fc = '0;
          else fc = fc + 1'b1;
        end else begin
          cr   = 1'b0;
          e[1] = '0;
          e[0] = b;
          fc   = FC_W'(1);
        end

        res.frame_length = fc[8:0];
        if (fin) begin
          if (e[0] == HEAD_ZIGBEE) ev = EV_ZIGBEE;
          else if (e[0] == HEAD_CRLF && e[1] == CUSTOM_B1 && e[2] == CUSTOM_B2 &&
                   e[3] == CUSTOM_B3) ev = EV_CUSTOM;
          else ev = EV_DISCARD;
          fc   = '0;
          cr   = 1'b0;
          e[0] = '0;
        end
      end
      OP_READ: begin
        res.frame_length = fc[8:0];
        if (ridx < FC_W'(4)) begin
          res.reg_data = ent_r[read_index[1:0]];
        end else if (ridx < FC_W'(BUF_DEPTH)) begin
          res.from_mem = 1'b1;
          mem_re       = accept;
        end
      end
      OP_CLR_MODE: begin
        md               = 1'b0;
        res.frame_length = fc[8:0];
      end
      default: begin
        res.frame_length = fc[8:0];
      end
    endcase

    res.event_res = ev;
    res.mode_flag = md;

    fill_nxt = accept ? fc : fill_r;
    cr_nxt   = accept ? cr : cr_r;
    mode_nxt = accept ? md : mode_r;
    ent_nxt  = accept ? e : ent_r;

    mem_we    = '0;
    mem_wrow  = '{default: '0};
    mem_wdata = '{default: '0};
    if (clr_active_r) begin
      mem_we    = 2'b11;
      mem_wrow  = '{clr_row_r, clr_row_r};
      mem_wdata = '{8'h00, 8'h00};
    end else if (accept) begin
      // a kept CR pair lands on consecutive entries, so one per bank
      for (int k = 0; k < 2; k++) begin
        if (pv[k] && pa[k] < FC_W'(BUF_DEPTH)) begin
          sh = pa[k] >> 1;
          mem_we[pa[k][0]]    = 1'b1;
          mem_wrow[pa[k][0]]  = sh[ROW_W-1:0];
          mem_wdata[pa[k][0]] = pd[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      cr_r         <= 1'b0;
      mode_r       <= 1'b0;
      ent_r        <= '{default: '0};
      clr_active_r <= 1'b1;
      clr_row_r    <= '0;
    end else begin
      fill_r <= fill_nxt;
      cr_r   <= cr_nxt;
      mode_r <= mode_nxt;
      ent_r  <= ent_nxt;
      if (clr_active_r) begin
        if (clr_row_r == ROW_W'(ROWS - 1)) clr_active_r <= 1'b0;
        clr_row_r <= clr_row_r + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/multi_format_frame_receiver.sv =====
// Serial frame receiver: each item is a received byte, a buffer read or a mode-flag clear,
// and each item gives exactly one result. The byte at buffer entry 0 picks the frame format
// (0x55 length-prefixed, 0xC1 ended by CR LF, 'B' followed by U/S/Y for mode entry).
// One item is taken per clock while no clearing pass runs and the output is free or taken;
// its result is registered at acceptance, with buffer reads served from the registered port
// of the buffer memory. The buffer is split into even and odd entry banks so the two-byte
// store of a kept CR writes both banks in the same cycle. After reset a clearing pass zeroes
// the buffer, one row of both banks per cycle; no item is accepted until it ends.
module multi_format_frame_receiver #(
  parameter int BUF_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  mfr_in_if.sink     in_ch,
  mfr_out_if.source  out_ch
);
  import mfr_pkg::*;

  localparam int ROWS  = (BUF_DEPTH + 1) / 2;
  localparam int ROW_W = $clog2(ROWS);

  logic             busy;
  logic             accept;
  logic [1:0]       mem_we;
  logic [ROW_W-1:0] mem_wrow [2];
  logic [7:0]       mem_wdata [2];
  logic             mem_re;
  logic [ROW_W-1:0] mem_rrow;
  logic [7:0]       mem_rdata [2];
  res_t             res;
  res_t             res_r;
  logic             out_valid_r;

  assign in_ch.ready = !busy && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  mfr_frame_ctrl #(.BUF_DEPTH(BUF_DEPTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .operation  (in_ch.operation),
    .rx_byte    (in_ch.rx_byte),
    .read_index (in_ch.read_index),
    .busy       (busy),
    .mem_we     (mem_we),
    .mem_wrow   (mem_wrow),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_rrow   (mem_rrow),
    .res        (res)
  );

  for (genvar g = 0; g < 2; g++) begin : g_bank
    mfr_bank_ram #(.ROWS(ROWS)) u_bank (
      .clk   (clk),
      .we    (mem_we[g]),
      .wrow  (mem_wrow[g]),
      .wdata (mem_wdata[g]),
      .re    (mem_re),
      .rrow  (mem_rrow),
      .rdata (mem_rdata[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept || (out_valid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  // bank read data holds while stalled, since no read is issued then
  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_res    = res_r.event_res;
  assign out_ch.frame_length = res_r.frame_length;
  assign out_ch.mode_flag    = res_r.mode_flag;
  assign out_ch.read_data    = res_r.from_mem ? (res_r.bank_odd ? mem_rdata[1] : mem_rdata[0])
                                              : res_r.reg_data;

endmodule

// ===== tb/multi_format_frame_receiver_tb.sv =====
module multi_format_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mfr_pkg::*;

  localparam int         BUF_DEPTH       = 256;
  localparam logic [1:0] OP_SPARE        = 2'd3;
  localparam logic [7:0] HEAD_EMPTY      = 8'h00;
  localparam logic [7:0] FILLER          = 8'h7E;
  localparam int         QUIET_LIMIT     = 5000;
  localparam int         ITEMS_PER_PHASE = 30;

  typedef struct packed {
    event_t     ev;
    logic [8:0] len;
    logic [7:0] data;
    logic       mode;
  } rx_result_t;

  class frame_scoreboard;
    bit [7:0]    buf_mem [BUF_DEPTH];
    int unsigned fill;
    bit          cr_mark;
    bit          mode_on;
    rx_result_t  pending [$];
    int          errors;

    function new();
      foreach (buf_mem[i]) buf_mem[i] = 8'h00;
      fill    = 0;
      cr_mark = 1'b0;
      mode_on = 1'b0;
      errors  = 0;
    endfunction

    function void store(int unsigned at, bit [7:0] v);
      if (at < BUF_DEPTH) buf_mem[at] = v;
    endfunction

    function void restart_head(bit [7:0] b);
      cr_mark    = 1'b0;
      buf_mem[1] = 8'h00;
      buf_mem[0] = b;
      fill       = 1;
    endfunction

    // CR LF frames wrap the fill count but keep the head entry
    function void crlf_wrap();
      if (fill > BUF_DEPTH - 1) begin
        fill    = 0;
        cr_mark = 1'b0;
      end
    endfunction

    // returns 1 when the byte completes a frame
    function bit absorb_byte(bit [7:0] b, inout event_t ev);
      int unsigned want;
      if (buf_mem[0] == HEAD_CRLF) begin
        if (cr_mark) begin
          if (b == CHAR_LF) return 1'b1;
          cr_mark = 1'b0;
          store(fill, CHAR_CR);
          fill++;
          store(fill, b);
          fill++;
          crlf_wrap();
        end else if (b == CHAR_CR) begin
          cr_mark = 1'b1;
        end else begin
          store(fill, b);
          fill++;
          crlf_wrap();
        end
      end else if (buf_mem[0] == HEAD_ZIGBEE) begin
        store(fill, b);
        fill++;
        want = buf_mem[1] + 2;
        if (want == fill) return 1'b1;
        if (want < fill) begin
          fill       = 0;
          cr_mark    = 1'b0;
          buf_mem[0] = 8'h00;
          buf_mem[1] = 8'h00;
        end
      end else if (buf_mem[0] == HEAD_MODE) begin
        if (b != CHAR_U && b != CHAR_S && b != CHAR_Y) begin
          restart_head(b);
        end else begin
          store(fill, b);
          fill++;
        end
        if (fill == 4) begin
          if (!mode_on) begin
            mode_on = 1'b1;
            ev      = EV_MODE;
          end
        end else if (fill > 4) begin
          restart_head(b);
        end
      end else if (buf_mem[0] == HEAD_EMPTY) begin
        buf_mem[1] = 8'h00;
        buf_mem[0] = b;
        fill = (fill + 1 > BUF_DEPTH - 1) ? 0 : fill + 1;
      end else begin
        restart_head(b);
      end
      return 1'b0;
    endfunction

    function void note_input(logic [1:0] op, logic [7:0] b, logic [7:0] idx);
      rx_result_t r;
      event_t     ev;
      ev     = EV_NONE;
      r.data = 8'h00;
      r.len  = fill[8:0];
      case (op)
        OP_RX: begin
          if (absorb_byte(b, ev)) begin
            if (buf_mem[0] == HEAD_ZIGBEE)
              ev = EV_ZIGBEE;
            else if (buf_mem[0] == HEAD_CRLF && buf_mem[1] == CUSTOM_B1 &&
                     buf_mem[2] == CUSTOM_B2 && buf_mem[3] == CUSTOM_B3)
              ev = EV_CUSTOM;
            else
              ev = EV_DISCARD;
            r.len      = fill[8:0];
            fill       = 0;
            cr_mark    = 1'b0;
            buf_mem[0] = 8'h00;
          end else begin
            r.len = fill[8:0];
          end
        end
        OP_READ: begin
          if (idx < BUF_DEPTH) r.data = buf_mem[idx];
        end
        OP_CLR_MODE: begin
          mode_on = 1'b0;
        end
        default: ;
      endcase
      r.ev   = ev;
      r.mode = mode_on;
      pending.push_back(r);
    endfunction

    function void check_result(rx_result_t got);
      rx_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: ev=%0d len=%0d data=%02h mode=%0d",
                   got.ev, got.len, got.data, got.mode);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: expected ev=%0d len=%0d data=%02h mode=%0d,",
                    " got ev=%0d len=%0d data=%02h mode=%0d"},
                   want.ev, want.len, want.data, want.mode,
                   got.ev, got.len, got.data, got.mode);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  mfr_in_if  in_ch();
  mfr_out_if out_ch();

  multi_format_frame_receiver #(.BUF_DEPTH(BUF_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  frame_scoreboard sb;
  int         gap_pct;
  int         stall_pct;
  int         read_mix_pct;
  int         items_sent;
  int         quiet_cycles;
  rx_result_t seen;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.ev   = event_t'(out_ch.event_res);
      seen.len  = out_ch.frame_length;
      seen.data = out_ch.read_data;
      seen.mode = out_ch.mode_flag;
      sb.check_result(seen);
    end
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: cycles in a row with no item moving on either side
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] b,
                           input logic [7:0] idx);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.rx_byte    <= b;
    in_ch.read_index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(op, b, idx);
    items_sent++;
  endtask

  // received byte, now and then preceded by a buffer read
  task automatic push_byte(input logic [7:0] b);
    if ($urandom_range(99) < read_mix_pct)
      send_item(OP_READ, 8'($urandom),
                $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom_range(255)));
    send_item(OP_RX, b, 8'($urandom));
  endtask

  function automatic logic [7:0] mode_char();
    case ($urandom_range(2))
      0:       return CHAR_U;
      1:       return CHAR_S;
      default: return CHAR_Y;
    endcase
  endfunction

  // bring the receiver to a state where the next byte opens a new frame, so it starts clean
  task automatic resync();
    if (sb.buf_mem[0] == HEAD_CRLF) begin
      if (!sb.cr_mark) push_byte(CHAR_CR);
      push_byte(CHAR_LF);
    end else if (sb.buf_mem[0] == HEAD_ZIGBEE) begin
      while (sb.buf_mem[0] == HEAD_ZIGBEE) push_byte(8'($urandom));
    end else if (sb.buf_mem[0] == HEAD_MODE || sb.fill != 0) begin
      push_byte(FILLER);
    end
  endtask

  task automatic random_sequence();
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 70 && $urandom_range(99) < 85) resync();
    if (kind < 25) begin
      n = $urandom_range(12);
      // leftover fill in front of the head makes the length overrun
      if ($urandom_range(9) == 0) begin
        push_byte(HEAD_EMPTY);
        push_byte(HEAD_EMPTY);
      end
      push_byte(HEAD_ZIGBEE);
      push_byte(n[7:0]);
      if ($urandom_range(9) == 0) n = $urandom_range(n);
      repeat (n) push_byte(8'($urandom));
    end else if (kind < 45) begin
      push_byte(HEAD_CRLF);
      if ($urandom_range(1)) begin
        push_byte(CUSTOM_B1);
        push_byte(CUSTOM_B2);
        push_byte(CUSTOM_B3);
      end
      repeat ($urandom_range(10))
        push_byte($urandom_range(9) == 0 ? CHAR_CR : 8'($urandom));
      push_byte(CHAR_CR);
      if ($urandom_range(9) != 0) push_byte(CHAR_LF);
    end else if (kind < 60) begin
      push_byte(HEAD_MODE);
      repeat (3) push_byte($urandom_range(4) == 0 ? 8'($urandom) : mode_char());
      if ($urandom_range(4) == 0) push_byte(mode_char());
    end else if (kind < 70) begin
      repeat ($urandom_range(1, 5)) push_byte(HEAD_EMPTY);
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(3))
          0: send_item(OP_READ, 8'($urandom), 8'($urandom));
          1: send_item(OP_CLR_MODE, 8'($urandom), 8'($urandom));
          2: send_item(OP_SPARE, 8'($urandom), 8'($urandom));
          default: send_item(OP_READ, 8'($urandom), 8'($urandom_range(7)));
        endcase
      end
    end
  endtask

  // the few long runs: full-length zigbee frame, CR LF wrap, empty-head wrap
  task automatic big_sequence(input int which);
    logic [7:0] v;
    resync();
    case (which)
      1: begin
        push_byte(HEAD_ZIGBEE);
        push_byte(8'hFF);
        repeat (255) push_byte(8'($urandom));
      end
      2: begin
        push_byte(HEAD_CRLF);
        repeat (256) begin
          v = 8'($urandom);
          if (v == CHAR_CR) v = FILLER;
          push_byte(v);
        end
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
      end
      default: repeat (256) push_byte(HEAD_EMPTY);
    endcase
  endtask

  initial begin
    logic [7:0] opening [26];
    int         phase_end;
    int         mark;
    bit         big_done;

    sb               = new();
    gap_pct          = 0;
    stall_pct        = 0;
    read_mix_pct     = 0;
    items_sent       = 0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.operation  = OP_RX;
    in_ch.rx_byte    = 8'h00;
    in_ch.read_index = 8'h00;
    out_ch.ready     = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // zigbee, custom, lone CR kept as data, length overrun, mode entry, then again while the flag is set
    opening = '{HEAD_ZIGBEE, 8'h01, 8'hFF,
                HEAD_CRLF, CUSTOM_B1, CUSTOM_B2, CUSTOM_B3, CHAR_CR, CHAR_LF,
                HEAD_CRLF, CHAR_CR, 8'h00, CHAR_CR, CHAR_LF,
                HEAD_EMPTY, HEAD_EMPTY, HEAD_ZIGBEE, 8'h07,
                HEAD_MODE, CHAR_U, CHAR_S, CHAR_Y,
                HEAD_MODE, CHAR_U, CHAR_S, CHAR_Y};
    send_item(OP_READ, 8'($urandom), 8'd0);
    send_item(OP_READ, 8'($urandom), 8'd255);
    send_item(OP_SPARE, 8'($urandom), 8'($urandom));
    foreach (opening[i]) push_byte(opening[i]);
    send_item(OP_CLR_MODE, 8'($urandom), 8'($urandom));

    read_mix_pct = 6;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 49; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 49; end
        default: begin gap_pct = 16; stall_pct = 16; end
      endcase
      phase_end = items_sent + ITEMS_PER_PHASE;
      big_done  = (p == 0);
      while (items_sent < phase_end) begin
        if (!big_done && items_sent >= phase_end - ITEMS_PER_PHASE / 2) begin
          mark = items_sent;
          big_sequence(p);
          phase_end += items_sent - mark;
          big_done = 1'b1;
        end else begin
          random_sequence();
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
